// ----- design/kdpc_pkg.sv -----
// kdpc_pkg: shared types and constants for the key debounce and press classifier.
// Used by every module in design/; depends on nothing.
package kdpc_pkg;

  localparam int NUM_KEYS_DEF = 8;
  localparam int MAX_RESULTS  = 16;
  localparam int QUEUE_DEPTH  = 4;
  localparam int SEQ_W        = 32;

  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_LONG     = 2'd1;
  localparam logic [1:0] CFG_PERIOD   = 2'd2;

  typedef enum logic [2:0] {
    EV_PRESS   = 3'd0,
    EV_RELEASE = 3'd1,
    EV_SHORT   = 3'd2,
    EV_LONG    = 3'd3,
    EV_REPEAT  = 3'd4
  } event_kind_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_WALK,
    FS_SECOND,
    FS_FLUSH
  } front_state_t;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [7:0]  long_press_counts;
    logic [15:0] press_period_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       key_index;
    event_kind_t      kind;
    logic [SEQ_W-1:0] seq;
    logic             last;
  } event_t;

  typedef struct packed {
    logic   valid;
    event_t ev;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- design/kdpc_front.sv -----
// kdpc_front: walks the keys of one tick, one per cycle unless the queue is full,
// and classifies events. Holds all per-key state. Depends on kdpc_pkg.
module kdpc_front #(
  parameter int NUM_KEYS = kdpc_pkg::NUM_KEYS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [7:0]        key_levels,
  output logic              in_stall,
  input  kdpc_pkg::cfg_t    cfg,
  input  kdpc_pkg::q_stat_t q_stat,
  output kdpc_pkg::q_push_t push
);

  localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int LW = 2 ** KW;
  localparam int NW = $clog2(kdpc_pkg::MAX_RESULTS + 1);

  kdpc_pkg::front_state_t state, state_next;

  logic [KW-1:0] kidx;
  logic [7:0]    levels;
  logic [NW-1:0] n_cnt;
  kdpc_pkg::event_t pend;
  logic          pend_valid;

  logic [7:0]                 db_cnt   [NUM_KEYS];
  logic                       stable   [NUM_KEYS];
  logic [7:0]                 hold_cnt [NUM_KEYS];
  logic [15:0]                per_cnt  [NUM_KEYS];
  logic [kdpc_pkg::SEQ_W-1:0] pseq     [NUM_KEYS];
  logic [kdpc_pkg::SEQ_W-1:0] gseq;

  // key step datapath
  logic [LW-1:0]              levels_ext;
  logic                       lvl;
  logic [7:0]                 cnt;
  logic [7:0]                 db_next;
  logic                       settling;
  logic                       change;
  logic                       stable_next;
  logic [7:0]                 hold_next;
  logic [15:0]                per_next;
  logic [kdpc_pkg::SEQ_W-1:0] pseq_next;
  logic [kdpc_pkg::SEQ_W-1:0] gseq_next;
  logic [16:0]                p_inc;
  logic [8:0]                 h_inc;
  logic                       first_valid;
  kdpc_pkg::event_kind_t      first_kind;
  logic                       second;

  // control
  logic                  last_key;
  logic                  room;
  logic                  emit_req;
  kdpc_pkg::event_kind_t emit_kind;
  kdpc_pkg::event_t      emit_ev;
  logic                  advance;

  assign levels_ext = LW'(levels);
  assign lvl        = levels_ext[kidx];
  assign cnt        = db_cnt[kidx];
  assign last_key   = (kidx == KW'(NUM_KEYS - 1));
  assign room       = (n_cnt < NW'(kdpc_pkg::MAX_RESULTS));
  assign in_stall   = (state != kdpc_pkg::FS_IDLE);

  always_comb begin
    if (lvl) begin
      db_next = (cnt < cfg.debounce_ticks) ? cnt + 8'd1 : cnt;
    end else begin
      db_next = (cnt != 8'd0) ? cnt - 8'd1 : cnt;
    end
    settling = (db_next != 8'd0) && (db_next < cfg.debounce_ticks);
    change   = !settling && (stable[kidx] != lvl);

    stable_next = stable[kidx];
    hold_next   = hold_cnt[kidx];
    per_next    = per_cnt[kidx];
    pseq_next   = pseq[kidx];
    gseq_next   = gseq;
    p_inc       = {1'b0, per_cnt[kidx]} + 17'd1;
    h_inc       = {1'b0, hold_cnt[kidx]} + 9'd1;
    first_valid = 1'b0;
    first_kind  = kdpc_pkg::EV_PRESS;
    second      = 1'b0;

    if (change && lvl) begin
      stable_next = 1'b1;
      gseq_next   = gseq + 1'b1;
      pseq_next   = gseq + 1'b1;
      per_next    = 16'd0;
      first_valid = 1'b1;
    end else if (change) begin
      stable_next = 1'b0;
      hold_next   = 8'd0;
      per_next    = 16'd0;
      first_valid = 1'b1;
      // short goes first, release follows in the FS_SECOND state
      if (hold_cnt[kidx] < cfg.long_press_counts) begin
        first_kind = kdpc_pkg::EV_SHORT;
        second     = 1'b1;
      end else begin
        first_kind = kdpc_pkg::EV_RELEASE;
      end
    end else if (stable[kidx]) begin
      if (p_inc >= {1'b0, cfg.press_period_ticks}) begin
        per_next = 16'd0;
        if (h_inc == {1'b0, cfg.long_press_counts}) begin
          hold_next   = h_inc[7:0];
          first_valid = 1'b1;
          first_kind  = kdpc_pkg::EV_LONG;
        end else if (h_inc > {1'b0, cfg.long_press_counts}) begin
          first_valid = 1'b1;
          first_kind  = kdpc_pkg::EV_REPEAT;
        end else begin
          hold_next = h_inc[7:0];
        end
      end else begin
        per_next = p_inc[15:0];
      end
    end
  end

  // outputs of the walk sequencer
  always_comb begin
    emit_req   = 1'b0;
    emit_kind  = kdpc_pkg::EV_RELEASE;
    push.valid = 1'b0;
    push.ev    = pend;
    push.ev.last = 1'b0;
    unique case (state)
      kdpc_pkg::FS_IDLE: begin
      end
      kdpc_pkg::FS_WALK: begin
        emit_req   = first_valid && room;
        emit_kind  = first_kind;
        push.valid = emit_req && pend_valid;
      end
      kdpc_pkg::FS_SECOND: begin
        emit_req   = room;
        push.valid = emit_req && pend_valid;
      end
      kdpc_pkg::FS_FLUSH: begin
        push.valid   = pend_valid;
        push.ev.last = 1'b1;
      end
    endcase
    advance = !(push.valid && q_stat.full);

    emit_ev.key_index = 3'(kidx);
    emit_ev.kind      = emit_kind;
    emit_ev.seq       = (state == kdpc_pkg::FS_WALK) ? pseq_next : pseq[kidx];
    emit_ev.last      = 1'b0;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      kdpc_pkg::FS_IDLE: begin
        if (in_valid) state_next = kdpc_pkg::FS_WALK;
      end
      kdpc_pkg::FS_WALK: begin
        if (advance) begin
          if (second) state_next = kdpc_pkg::FS_SECOND;
          else if (last_key) state_next = kdpc_pkg::FS_FLUSH;
        end
      end
      kdpc_pkg::FS_SECOND: begin
        if (advance) state_next = last_key ? kdpc_pkg::FS_FLUSH : kdpc_pkg::FS_WALK;
      end
      kdpc_pkg::FS_FLUSH: begin
        if (advance) state_next = kdpc_pkg::FS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= kdpc_pkg::FS_IDLE;
      kidx       <= '0;
      n_cnt      <= '0;
      pend_valid <= 1'b0;
      gseq       <= '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        db_cnt[i]   <= 8'd0;
        stable[i]   <= 1'b0;
        hold_cnt[i] <= 8'd0;
        per_cnt[i]  <= 16'd0;
        pseq[i]     <= '0;
      end
    end else begin
      state <= state_next;
      if (state == kdpc_pkg::FS_IDLE && in_valid) begin
        levels <= key_levels;
        kidx   <= '0;
        n_cnt  <= '0;
      end
      if (state == kdpc_pkg::FS_WALK && advance) begin
        db_cnt[kidx]   <= db_next;
        stable[kidx]   <= stable_next;
        hold_cnt[kidx] <= hold_next;
        per_cnt[kidx]  <= per_next;
        pseq[kidx]     <= pseq_next;
        gseq           <= gseq_next;
        if (!second && !last_key) kidx <= kidx + 1'b1;
      end
      if (state == kdpc_pkg::FS_SECOND && advance && !last_key) begin
        kidx <= kidx + 1'b1;
      end
      // newest event waits in pend until we know whether it ends the tick
      if (emit_req && advance) begin
        pend       <= emit_ev;
        pend_valid <= 1'b1;
        n_cnt      <= n_cnt + 1'b1;
      end
      if (state == kdpc_pkg::FS_FLUSH && advance) begin
        pend_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/kdpc_queue.sv -----
// kdpc_queue: short event queue between the classifier front and the output stage.
// Depth from kdpc_pkg::QUEUE_DEPTH. Depends on kdpc_pkg.
module kdpc_queue (
  input  logic              clk,
  input  logic              rst,
  input  kdpc_pkg::q_push_t push,
  input  logic              pop,
  output kdpc_pkg::q_stat_t stat,
  output kdpc_pkg::event_t  head
);

  localparam int DEPTH = kdpc_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  kdpc_pkg::event_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push.valid && !stat.full;
  assign do_pop     = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        entries[wr_ptr] <= push.ev;
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

// ----- design/kdpc_back.sv -----
// kdpc_back: output register stage, drains the event queue onto the result channel.
// Depends on kdpc_pkg.
module kdpc_back (
  input  logic              clk,
  input  logic              rst,
  input  kdpc_pkg::q_stat_t q_stat,
  input  kdpc_pkg::event_t  q_head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output kdpc_pkg::event_t  ev
);

  assign pop = !q_stat.empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        ev        <= q_head;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/key_debounce_press_classifier.sv -----
// key_debounce_press_classifier: top level, config registers and the front/queue/back chain.
// Depends on kdpc_pkg, kdpc_front, kdpc_queue, kdpc_back.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_stall  | key_levels
//  out     | out_valid / out_stall| key_index, event_kind, sequence_number, last_of_tick
//  cfg     | cfg_wen              | cfg_index, cfg_data
//
// A tick is taken only while the front is idle; it then walks one key per cycle while the
// event queue has room, with an extra FS_SECOND step for each key that gives short plus
// release and an FS_FLUSH step to close the tick, set by the single-key walk sequencer.
// A full event queue holds the walk; out_stall only backs up the queue and output register.
// Synchronous reset returns all keys to released with zero counters and restores the
// register defaults.
module key_debounce_press_classifier #(
  parameter int NUM_KEYS = kdpc_pkg::NUM_KEYS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  key_levels,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  key_index,
  output logic [2:0]  event_kind,
  output logic [31:0] sequence_number,
  output logic        last_of_tick,
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  kdpc_pkg::cfg_t    cfg;
  kdpc_pkg::q_push_t push;
  kdpc_pkg::q_stat_t q_stat;
  kdpc_pkg::event_t  q_head;
  kdpc_pkg::event_t  ev;
  logic              pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks     <= 8'd4;
      cfg.long_press_counts  <= 8'd2;
      cfg.press_period_ticks <= 16'd150;
    end else if (cfg_wen) begin
      if (cfg_index == kdpc_pkg::CFG_DEBOUNCE) cfg.debounce_ticks <= cfg_data[7:0];
      if (cfg_index == kdpc_pkg::CFG_LONG)     cfg.long_press_counts <= cfg_data[7:0];
      if (cfg_index == kdpc_pkg::CFG_PERIOD)   cfg.press_period_ticks <= cfg_data;
    end
  end

  kdpc_front #(
    .NUM_KEYS (NUM_KEYS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .key_levels (key_levels),
    .in_stall   (in_stall),
    .cfg        (cfg),
    .q_stat     (q_stat),
    .push       (push)
  );

  kdpc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .stat (q_stat),
    .head (q_head)
  );

  kdpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ev        (ev)
  );

  assign key_index       = ev.key_index;
  assign event_kind      = ev.kind;
  assign sequence_number = ev.seq;
  assign last_of_tick    = ev.last;

endmodule
